[rtl/core/indexed_min_heap_unit_assert.svh]
// Assertion macros for the indexed min-heap unit
`ifndef INDEXED_MIN_HEAP_UNIT_ASSERT_SVH
`define INDEXED_MIN_HEAP_UNIT_ASSERT_SVH
`define IMH_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`define IMH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[rtl/core/imh_pkg.sv]
// Shared types and codes for the indexed min-heap unit
package imh_pkg;
  localparam logic [2:0] FUNC_INSERT  = 3'd0;
  localparam logic [2:0] FUNC_SET     = 3'd1;
  localparam logic [2:0] FUNC_DELETE  = 3'd2;
  localparam logic [2:0] FUNC_SEARCH  = 3'd3;
  localparam logic [2:0] FUNC_MIN     = 3'd4;
  localparam logic [2:0] FUNC_MAX     = 3'd5;
  localparam logic [2:0] FUNC_EXTRACT = 3'd6;
  localparam logic [2:0] FUNC_UNUSED  = 3'd7;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_ERROR = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]  func;
    logic signed [63:0] key;
    logic [63:0] payload;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic signed [63:0] key_out;
    logic [5:0]  index_out;
    logic [63:0] payload_out;
  } rsp_t;
endpackage

[rtl/core/imh_req_if.sv]
// Request channel interface
interface imh_req_if;
  logic           valid;
  logic           ready;
  imh_pkg::req_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[rtl/core/imh_rsp_if.sv]
// Response channel interface
interface imh_rsp_if;
  logic           valid;
  logic           ready;
  imh_pkg::rsp_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[rtl/core/indexed_min_heap_unit.sv]
// Indexed min-heap unit: heap store in one key/payload memory with a sequencer
// Search, set, delete, insert and max scan entries in turn; min and extract read only the root.
// Delete and extract then move the last entry into the freed slot and sift it up or down as needed;
// insert sifts the new entry up from the end of the heap.
// One item at a time: a request is taken only when idle and no earlier response is still held.
// Reset: the entry count clears to zero; memory stays undefined until written, no clearing pass.
`include "indexed_min_heap_unit_assert.svh"

module indexed_min_heap_unit #(
  parameter int CAPACITY = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  imh_req_if.sink   req,
  imh_rsp_if.source rsp
);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_SCAN   = 4'd1;
  localparam logic [3:0] S_SCANW  = 4'd2;
  localparam logic [3:0] S_FOUND  = 4'd3;
  localparam logic [3:0] S_LASTW  = 4'd4;
  localparam logic [3:0] S_DEC    = 4'd5;
  localparam logic [3:0] S_RA     = 4'd6;
  localparam logic [3:0] S_RAW    = 4'd7;
  localparam logic [3:0] S_RB     = 4'd8;
  localparam logic [3:0] S_RBW    = 4'd9;
  localparam logic [3:0] S_RC     = 4'd10;
  localparam logic [3:0] S_RCW    = 4'd11;
  localparam logic [3:0] S_STEP   = 4'd12;
  localparam logic [3:0] S_OUT    = 4'd13;

  logic [127:0] mem [CAPACITY];
  logic [127:0] rd_q;
  logic [AW-1:0] ra;
  logic          we;
  logic [AW-1:0] wa;
  logic [127:0]  wd;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[ra];
  end

  logic [3:0]    st_q, st_d;
  logic [CW-1:0] cnt_q, cnt_d;
  imh_pkg::req_t rq_q, rq_d;
  imh_pkg::rsp_t out_q, out_d;
  logic          ov_q, ov_d;
  logic [CW-1:0] i_q, i_d;
  logic [CW-1:0] pos_q, pos_d;
  logic          found_q, found_d;
  logic [127:0]  cur_q, cur_d;
  logic [127:0]  b_q, b_d;
  logic [CW-1:0] pa_q, pa_d;
  logic          up_q, up_d;

  function automatic logic kless(input logic [127:0] x, input logic [127:0] y);
    return $signed(x[127:64]) < $signed(y[127:64]);
  endfunction

  logic [CW:0] l_w;
  assign l_w = {pos_q, 1'b1};

  assign req.ready = (st_q == S_IDLE) && (!ov_q || rsp.ready);
  assign rsp.valid = ov_q;
  assign rsp.payload = out_q;

  always_comb begin
    st_d = st_q; cnt_d = cnt_q; rq_d = rq_q; out_d = out_q; ov_d = ov_q;
    i_d = i_q; pos_d = pos_q; found_d = found_q; cur_d = cur_q;
    b_d = b_q; pa_d = pa_q; up_d = up_q;
    ra = '0; we = 1'b0; wa = '0; wd = '0;
    if (ov_q && rsp.ready) begin
      ov_d = 1'b0;
    end
    case (st_q)
      S_IDLE: begin
        if (req.valid && req.ready) begin
          rq_d = req.payload;
          i_d = '0; found_d = 1'b0; pos_d = '0;
          out_d = '0; out_d.status = imh_pkg::STATUS_ERROR;
          case (req.payload.func)
            imh_pkg::FUNC_INSERT, imh_pkg::FUNC_SET, imh_pkg::FUNC_DELETE,
            imh_pkg::FUNC_SEARCH, imh_pkg::FUNC_MAX:
              st_d = (cnt_q == '0) ? S_OUT : S_SCAN;
            imh_pkg::FUNC_MIN, imh_pkg::FUNC_EXTRACT:
              st_d = (cnt_q == '0) ? S_OUT : S_SCAN;
            default: st_d = S_OUT;
          endcase
          if (req.payload.func == imh_pkg::FUNC_INSERT && cnt_q == '0) begin
            st_d = S_FOUND;
          end
          if (req.payload.func == imh_pkg::FUNC_MIN
              || req.payload.func == imh_pkg::FUNC_EXTRACT) begin
            i_d = '0;
          end
        end
      end
      S_SCAN: begin
        ra = i_q[AW-1:0];
        st_d = S_SCANW;
      end
      S_SCANW: begin
        if (rq_q.func == imh_pkg::FUNC_MAX) begin
          if (i_q == '0 || kless(cur_q, rd_q)) begin
            cur_d = rd_q; pos_d = i_q;
          end
        end else if (rq_q.func == imh_pkg::FUNC_MIN || rq_q.func == imh_pkg::FUNC_EXTRACT) begin
          cur_d = rd_q; found_d = 1'b1; pos_d = '0;
        end else if (rd_q[127:64] == rq_q.key) begin
          cur_d = rd_q; found_d = 1'b1; pos_d = i_q;
        end
        if (rq_q.func == imh_pkg::FUNC_MIN || rq_q.func == imh_pkg::FUNC_EXTRACT
            || (rq_q.func != imh_pkg::FUNC_MAX && rd_q[127:64] == rq_q.key)
            || i_q + 1'b1 == cnt_q) begin
          st_d = S_FOUND;
        end else begin
          i_d = i_q + 1'b1;
          st_d = S_SCAN;
        end
      end
      S_FOUND: begin
        st_d = S_OUT;
        case (rq_q.func)
          imh_pkg::FUNC_INSERT: begin
            if (found_q) begin
              out_d.status = imh_pkg::STATUS_ERROR;
            end else if (cnt_q >= CW'(CAPACITY)) begin
              out_d.status = imh_pkg::STATUS_FULL;
            end else begin
              out_d.status = imh_pkg::STATUS_OK;
              cur_d = {rq_q.key, rq_q.payload};
              pos_d = cnt_q;
              cnt_d = cnt_q + 1'b1;
              up_d = 1'b1;
              st_d = S_RA;
            end
          end
          imh_pkg::FUNC_SET: begin
            if (found_q) begin
              out_d.status = imh_pkg::STATUS_OK;
              we = 1'b1; wa = pos_q[AW-1:0]; wd = {cur_q[127:64], rq_q.payload};
            end
          end
          imh_pkg::FUNC_SEARCH: begin
            if (found_q) begin
              out_d.status = imh_pkg::STATUS_OK;
              out_d.index_out = 6'(pos_q);
              out_d.payload_out = cur_q[63:0];
            end
          end
          imh_pkg::FUNC_MIN, imh_pkg::FUNC_MAX: begin
            out_d.status = imh_pkg::STATUS_OK;
            out_d.key_out = cur_q[127:64];
            out_d.index_out = 6'(pos_q);
            out_d.payload_out = cur_q[63:0];
          end
          imh_pkg::FUNC_DELETE, imh_pkg::FUNC_EXTRACT: begin
            if (found_q) begin
              out_d.status = imh_pkg::STATUS_OK;
              if (rq_q.func == imh_pkg::FUNC_EXTRACT) begin
                out_d.key_out = cur_q[127:64];
                out_d.payload_out = cur_q[63:0];
              end
              st_d = S_LASTW;
            end
          end
          default: st_d = S_OUT;
        endcase
      end
      S_LASTW: begin
        ra = AW'(cnt_q - 1'b1);
        st_d = S_DEC;
      end
      S_DEC: begin
        cnt_d = cnt_q - 1'b1;
        cur_d = rd_q;
        we = 1'b1; wa = pos_q[AW-1:0]; wd = rd_q;
        if (pos_q < cnt_q - 1'b1) begin
          up_d = 1'b0;
          st_d = S_RA;
          if (pos_q == '0) begin
            st_d = S_RB;
          end
        end else begin
          st_d = S_OUT;
        end
      end
      S_RA: begin
        // read parent
        if (pos_q == '0) begin
          if (up_q) begin
            we = 1'b1; wa = '0; wd = cur_q; st_d = S_OUT;
          end else begin
            st_d = S_RB;
          end
        end else begin
          pa_d = (pos_q - 1'b1) >> 1;
          ra = AW'((pos_q - 1'b1) >> 1);
          st_d = S_RAW;
        end
      end
      S_RAW: begin
        if (up_q) begin
          if (kless(cur_q, rd_q)) begin
            we = 1'b1; wa = pos_q[AW-1:0]; wd = rd_q;
            pos_d = pa_q;
            st_d = S_RA;
          end else begin
            we = 1'b1; wa = pos_q[AW-1:0]; wd = cur_q;
            st_d = S_OUT;
          end
        end else begin
          if (kless(rd_q, cur_q)) begin
            st_d = S_RB;
          end else begin
            up_d = 1'b1;
            st_d = S_RA;
          end
        end
      end
      S_RB: begin
        if (l_w >= (CW+1)'(cnt_q)) begin
          we = 1'b1; wa = pos_q[AW-1:0]; wd = cur_q; st_d = S_OUT;
        end else begin
          ra = AW'(l_w); pa_d = CW'(l_w);
          st_d = S_RBW;
        end
      end
      S_RBW: begin
        b_d = rd_q;
        st_d = ((l_w + 1'b1) < (CW+1)'(cnt_q)) ? S_RC : S_STEP;
      end
      S_RC: begin
        ra = AW'(l_w + 1'b1);
        st_d = S_RCW;
      end
      S_RCW: begin
        if (kless(rd_q, b_q)) begin
          b_d = rd_q; pa_d = CW'(l_w + 1'b1);
        end
        st_d = S_STEP;
      end
      S_STEP: begin
        if (kless(cur_q, b_q)) begin
          we = 1'b1; wa = pos_q[AW-1:0]; wd = cur_q; st_d = S_OUT;
        end else begin
          we = 1'b1; wa = pos_q[AW-1:0]; wd = b_q;
          pos_d = pa_q; st_d = S_RB;
        end
      end
      S_OUT: begin
        if (!ov_q || rsp.ready) begin
          ov_d = 1'b1;
          st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
      cnt_q <= '0;
      ov_q <= 1'b0;
    end else begin
      st_q <= st_d;
      cnt_q <= cnt_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rq_q <= rq_d; out_q <= out_d; i_q <= i_d; pos_q <= pos_d; found_q <= found_d;
    cur_q <= cur_d; b_q <= b_d; pa_q <= pa_d;
    up_q <= up_d;
  end

  `IMH_ASSERT_IMPL(a_cnt_range, 1'b1, cnt_q <= CW'(CAPACITY))
  `IMH_ASSERT_IMPL(a_ready_idle, req.ready, st_q == S_IDLE)
  `IMH_ASSERT_NEXT(a_out_hold, rsp.valid && !rsp.ready, rsp.valid && $stable(rsp.payload))
  `IMH_ASSERT_NEXT(a_cnt_step, st_q == S_IDLE, cnt_q == $past(cnt_q))
endmodule

[dv/imh_checker.sv]
// Checker for the indexed min-heap unit: predicts every response and compares it
module imh_checker #(
  parameter int CAPACITY = 64
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  imh_req_if    req,
  imh_rsp_if    rsp,
  output int    fail_count,
  output int    pending_count
);
  logic signed [63:0]   stored_keys [CAPACITY];
  logic [63:0]          stored_words [CAPACITY];
  int                   num_entries;
  imh_pkg::rsp_t        expected_rsps [$];
  int                   mismatches;

  assign fail_count = mismatches;

  function automatic int find_key(logic signed [63:0] k);
    for (int i = 0; i < num_entries; i++)
      if (stored_keys[i] == k) return i;
    return -1;
  endfunction

  function automatic void swap_entries(int a, int b);
    logic signed [63:0] tk;
    logic [63:0]        tw;
    tk = stored_keys[a];  stored_keys[a] = stored_keys[b];  stored_keys[b] = tk;
    tw = stored_words[a]; stored_words[a] = stored_words[b]; stored_words[b] = tw;
  endfunction

  function automatic void bubble_up(int pos);
    int up;
    while (pos > 0) begin
      up = (pos - 1) / 2;
      if (!(stored_keys[pos] < stored_keys[up])) break;
      swap_entries(pos, up);
      pos = up;
    end
  endfunction

  function automatic void bubble_down(int pos);
    int l;
    int pick;
    forever begin
      l = 2 * pos + 1;
      if (l >= num_entries) break;
      pick = l;
      if (l + 1 < num_entries && stored_keys[l + 1] < stored_keys[l]) pick = l + 1;
      if (stored_keys[pos] < stored_keys[pick]) break;
      swap_entries(pos, pick);
      pos = pick;
    end
  endfunction

  function automatic void remove_at(int pos);
    int last;
    last = num_entries - 1;
    stored_keys[pos]  = stored_keys[last];
    stored_words[pos] = stored_words[last];
    num_entries = last;
    if (pos < num_entries) begin
      if (pos == 0 || stored_keys[(pos - 1) / 2] < stored_keys[pos]) bubble_down(pos);
      else bubble_up(pos);
    end
  endfunction

  function automatic imh_pkg::rsp_t heap_response(imh_pkg::req_t r);
    imh_pkg::rsp_t o;
    int            pos;
    o = '0;
    o.status = imh_pkg::STATUS_ERROR;
    case (r.func)
      imh_pkg::FUNC_INSERT: begin
        if (find_key(r.key) >= 0) o.status = imh_pkg::STATUS_ERROR;
        else if (num_entries >= CAPACITY) o.status = imh_pkg::STATUS_FULL;
        else begin
          stored_keys[num_entries]  = r.key;
          stored_words[num_entries] = r.payload;
          num_entries++;
          bubble_up(num_entries - 1);
          o.status = imh_pkg::STATUS_OK;
        end
      end
      imh_pkg::FUNC_SET: begin
        pos = find_key(r.key);
        if (pos >= 0) begin
          stored_words[pos] = r.payload;
          o.status = imh_pkg::STATUS_OK;
        end
      end
      imh_pkg::FUNC_DELETE: begin
        pos = find_key(r.key);
        if (pos >= 0) begin
          remove_at(pos);
          o.status = imh_pkg::STATUS_OK;
        end
      end
      imh_pkg::FUNC_SEARCH: begin
        pos = find_key(r.key);
        if (pos >= 0) begin
          o.index_out   = pos[5:0];
          o.payload_out = stored_words[pos];
          o.status      = imh_pkg::STATUS_OK;
        end
      end
      imh_pkg::FUNC_MIN: begin
        if (num_entries > 0) begin
          o.key_out     = stored_keys[0];
          o.payload_out = stored_words[0];
          o.status      = imh_pkg::STATUS_OK;
        end
      end
      imh_pkg::FUNC_MAX: begin
        if (num_entries > 0) begin
          pos = 0;
          for (int i = 1; i < num_entries; i++)
            if (stored_keys[pos] < stored_keys[i]) pos = i;
          o.key_out     = stored_keys[pos];
          o.index_out   = pos[5:0];
          o.payload_out = stored_words[pos];
          o.status      = imh_pkg::STATUS_OK;
        end
      end
      imh_pkg::FUNC_EXTRACT: begin
        if (num_entries > 0) begin
          o.key_out     = stored_keys[0];
          o.payload_out = stored_words[0];
          remove_at(0);
          o.status      = imh_pkg::STATUS_OK;
        end
      end
      default: o.status = imh_pkg::STATUS_ERROR;
    endcase
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    imh_pkg::rsp_t want;
    if (!rst_ni) begin
      num_entries   = 0;
      mismatches    = 0;
      expected_rsps.delete();
      pending_count = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_rsps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected response %p", rsp.payload);
        end else begin
          want = expected_rsps.pop_front();
          if (rsp.payload.status !== want.status || rsp.payload.key_out !== want.key_out ||
              rsp.payload.index_out !== want.index_out ||
              rsp.payload.payload_out !== want.payload_out) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %p, got %p", want, rsp.payload);
          end
        end
      end
      if (req.valid && req.ready) expected_rsps.push_back(heap_response(req.payload));
      pending_count = expected_rsps.size();
    end
  end
endmodule

[dv/tb_top.sv]
// Testbench top for the indexed min-heap unit: stimulus, stalls and verdict
module tb_top;
  localparam int CAPACITY   = 64;
  localparam int IDLE_LIMIT = 20000;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending_count;
  int   idle_cycles;
  bit   long_hold;
  bit   stim_done;

  logic signed [63:0] key_pool [$];

  imh_req_if req ();
  imh_rsp_if rsp ();

  indexed_min_heap_unit #(.CAPACITY(CAPACITY)) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req   (req),
    .rsp   (rsp)
  );

  imh_checker #(.CAPACITY(CAPACITY)) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req          (req),
    .rsp          (rsp),
    .fail_count   (fail_count),
    .pending_count(pending_count)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  function automatic logic signed [63:0] random_key();
    return {$urandom, $urandom};
  endfunction

  function automatic logic signed [63:0] pool_key();
    if (key_pool.size() == 0 || $urandom_range(9) == 0) return random_key();
    return key_pool[$urandom_range(key_pool.size() - 1)];
  endfunction

  task automatic send(logic [2:0] f, logic signed [63:0] k, logic [63:0] p);
    req.payload <= '{func: f, key: k, payload: p};
    req.valid   <= 1'b1;
    do @(posedge clk_i); while (!req.ready);
    @(negedge clk_i);
    if (f == imh_pkg::FUNC_INSERT && key_pool.size() < 200) key_pool.push_back(k);
  endtask

  task automatic pause(int n);
    req.valid <= 1'b0;
    repeat (n) @(negedge clk_i);
  endtask

  task automatic random_item(int fill_bias);
    int sel;
    logic [2:0] f;
    sel = $urandom_range(99);
    if (sel < fill_bias) f = imh_pkg::FUNC_INSERT;
    else if (sel < 97) f = 3'($urandom_range(1, 6));
    else f = 3'($urandom_range(7));
    send(f, (f == imh_pkg::FUNC_INSERT && $urandom_range(3) != 0) ? random_key() : pool_key(),
         {$urandom, $urandom});
  endtask

  initial begin
    int burst;
    req.valid   = 1'b0;
    req.payload = '0;
    rst_ni      = 1'b0;
    stim_done   = 1'b0;
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send(imh_pkg::FUNC_MIN, 0, 0);
    send(imh_pkg::FUNC_MAX, 0, 0);
    send(imh_pkg::FUNC_EXTRACT, 0, 0);
    send(imh_pkg::FUNC_SEARCH, 5, 0);
    send(imh_pkg::FUNC_SET, 5, 1);
    send(imh_pkg::FUNC_DELETE, 5, 0);
    send(imh_pkg::FUNC_INSERT, 64'sh8000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
    send(imh_pkg::FUNC_INSERT, 64'sh7FFF_FFFF_FFFF_FFFF, 64'h0);
    send(imh_pkg::FUNC_INSERT, 0, 64'hA5A5_5A5A_A5A5_5A5A);
    send(imh_pkg::FUNC_INSERT, -1, 64'h1);
    send(imh_pkg::FUNC_INSERT, 0, 64'h2);
    send(imh_pkg::FUNC_MIN, 0, 0);
    send(imh_pkg::FUNC_MAX, 0, 0);
    send(imh_pkg::FUNC_SEARCH, -1, 0);
    send(imh_pkg::FUNC_SET, 64'sh7FFF_FFFF_FFFF_FFFF, 64'h5555_AAAA_5555_AAAA);
    send(imh_pkg::FUNC_SEARCH, 64'sh7FFF_FFFF_FFFF_FFFF, 0);
    send(imh_pkg::FUNC_UNUSED, 0, 0);
    send(imh_pkg::FUNC_DELETE, 0, 0);
    send(imh_pkg::FUNC_EXTRACT, 0, 0);
    send(imh_pkg::FUNC_DELETE, 64'sh7FFF_FFFF_FFFF_FFFF, 0);
    send(imh_pkg::FUNC_EXTRACT, 0, 0);
    send(imh_pkg::FUNC_EXTRACT, 0, 0);

    // fill to capacity, overflow, then stall the receiver so that requests back up
    for (int i = 0; i < CAPACITY + 2; i++)
      send(imh_pkg::FUNC_INSERT, random_key(), {$urandom, $urandom});
    send(imh_pkg::FUNC_MAX, 0, 0);
    send(imh_pkg::FUNC_SEARCH, pool_key(), 0);
    long_hold = 1'b1;
    for (int i = 0; i < 8; i++) send(imh_pkg::FUNC_SEARCH, pool_key(), 0);
    long_hold = 1'b0;
    for (int i = 0; i < 30; i++) send(imh_pkg::FUNC_DELETE, pool_key(), 0);
    for (int i = 0; i < 40; i++) send(imh_pkg::FUNC_EXTRACT, 0, 0);

    for (int n = 0; n < 1300; ) begin
      burst = $urandom_range(1, 20);
      for (int b = 0; b < burst; b++) begin
        random_item((n / 200) % 2 == 0 ? 55 : 25);
        n++;
      end
      if ($urandom_range(3) != 0) pause($urandom_range(1, 12));
    end
    req.valid <= 1'b0;
    stim_done = 1'b1;
  end

  always @(negedge clk_i or negedge rst_ni) begin
    int hold_count;
    if (!rst_ni) begin
      rsp.ready  <= 1'b0;
      hold_count = 0;
    end else if (long_hold && hold_count < 600) begin
      hold_count++;
      rsp.ready <= 1'b0;
    end else begin
      case ($urandom_range(3))
        0: rsp.ready <= 1'b1;
        1: rsp.ready <= ($urandom_range(4) != 0);
        2: rsp.ready <= ($urandom_range(1) != 0);
        default: rsp.ready <= ($urandom_range(7) == 0);
      endcase
    end
  end

  initial begin
    idle_cycles = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
      if (stim_done && pending_count == 0) begin
        repeat (1000) @(posedge clk_i);
        if (fail_count == 0 && pending_count == 0) begin
          $display("CHECK OK");
        end else begin
          $display("CHECK FAILED");
        end
        $finish;
      end
    end
  end
endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/imh_pkg.sv
rtl/core/imh_req_if.sv
rtl/core/imh_rsp_if.sv
rtl/core/indexed_min_heap_unit.sv
dv/imh_checker.sv
dv/tb_top.sv
